// ===== sv/dtgm_pkg.sv =====
// Types and constants shared by the debug trigger group matcher.
package dtgm_pkg;

    localparam int BITMAP_W = 16;
    localparam int CFG_W    = 5;
    localparam int CONDS    = 8;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [3:0]  group_index;
        logic [7:0]  flags;
        logic        group_enable;
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [7:0]  xreg;
        logic [7:0]  yreg;
        logic [15:0] read_addr;
        logic [15:0] write_addr;
        logic [7:0]  read_value;
        logic [7:0]  write_value;
    } t_in_word;

    typedef struct packed {
        logic [15:0] hit_groups;
        logic        any_hit;
    } t_out_word;

    typedef struct packed {
        logic        group_en;
        logic [7:0]  conds;
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [7:0]  xreg;
        logic [7:0]  yreg;
        logic [15:0] read_addr;
        logic [15:0] write_addr;
        logic [7:0]  read_value;
        logic [7:0]  write_value;
    } t_entry;

endpackage

// ===== sv/debug_trigger_group_matcher_core.sv =====
// Debug trigger group matcher: top level with load/check sequencer.
//
// A load word writes one group slot and busy stays low.
// A check word scans groups 0 to groups_in_use-1 (capped at GROUPS), one
// table read per clock from the group memory, so busy stays high through
// ST_SCAN, ST_DRAIN and ST_DONE, or only ST_DONE when no group is in use.
// The result is on o_result in the last busy cycle, for exactly one cycle
// with o_result_valid high. The receiver cannot stall, so the result must
// be captured in that cycle. Write i_cfg_data only while busy is low.
module debug_trigger_group_matcher_core #(
    parameter int GROUPS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  dtgm_pkg::t_in_word       i_in,
    output dtgm_pkg::t_out_word      o_result,
    output logic                     o_result_valid,
    input  logic                     i_cfg_we,
    input  logic [dtgm_pkg::CFG_W-1:0] i_cfg_data
);
    import dtgm_pkg::*;

    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW = $clog2(GROUPS + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_cfg;
    t_in_word            r_event, n_event;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [GW-1:0]       r_cmp_idx, n_cmp_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic [BITMAP_W-1:0] r_bitmap, n_bitmap;
    logic                r_any, n_any;

    logic     accept;
    logic     wr_en;
    logic     rd_en;
    t_entry   wr_data;
    t_entry   rd_data;
    logic     fire;

    assign accept = start && !busy;
    assign wr_en  = accept && (i_in.kind == KIND_LOAD) && (int'(i_in.group_index) < GROUPS);

    always_comb begin
        wr_data.group_en    = i_in.group_enable;
        wr_data.conds       = i_in.flags;
        wr_data.pc          = i_in.pc;
        wr_data.acc         = i_in.acc;
        wr_data.xreg        = i_in.xreg;
        wr_data.yreg        = i_in.yreg;
        wr_data.read_addr   = i_in.read_addr;
        wr_data.write_addr  = i_in.write_addr;
        wr_data.read_value  = i_in.read_value;
        wr_data.write_value = i_in.write_value;
    end

    assign rd_en = (r_state == ST_SCAN);

    dtgm_table #(
        .GROUPS (GROUPS),
        .GW     (GW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_idx  (GW'(i_in.group_index)),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_idx  (r_idx[GW-1:0]),
        .o_rd_data (rd_data)
    );

    dtgm_match u_match (
        .i_entry (rd_data),
        .i_event (r_event),
        .o_fire  (fire)
    );

    always_comb begin
        n_state   = r_state;
        n_event   = r_event;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmp_idx = r_idx[GW-1:0];
        n_cmp_vld = 1'b0;
        n_bitmap  = r_bitmap;
        n_any     = r_any;

        if (r_cmp_vld && fire) begin
            n_any    = 1'b1;
            n_bitmap = r_bitmap | (BITMAP_W'(1) << r_cmp_idx);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_in.kind == KIND_CHECK)) begin
                    n_event  = i_in;
                    n_idx    = '0;
                    n_bitmap = '0;
                    n_any    = 1'b0;
                    if (int'(r_cfg) > GROUPS) begin
                        n_count = CW'(GROUPS);
                    end else begin
                        n_count = CW'(r_cfg);
                    end
                    n_state = (r_cfg == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_cmp_vld = 1'b1;
                n_idx     = r_idx + CW'(1);
                if (r_idx == r_count - CW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_event   <= n_event;
        r_count   <= n_count;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_bitmap  <= n_bitmap;
        r_any     <= n_any;
    end

    assign busy                = (r_state != ST_IDLE);
    assign o_result_valid      = (r_state == ST_DONE);
    assign o_result.hit_groups = r_bitmap;
    assign o_result.any_hit    = r_any;

endmodule

// ===== sv/dtgm_table.sv =====
// Group table memory: one write port, one registered read port, per-entry valid bits.
module dtgm_table #(
    parameter int GROUPS = 16,
    parameter int GW     = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [GW-1:0]    i_wr_idx,
    input  dtgm_pkg::t_entry i_wr_data,
    input  logic             i_rd_en,
    input  logic [GW-1:0]    i_rd_idx,
    output dtgm_pkg::t_entry o_rd_data
);
    import dtgm_pkg::*;

    t_entry            r_mem [GROUPS];
    logic [GROUPS-1:0] r_valid;
    t_entry            r_rd_data;
    logic              r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_idx];
            end
        end
    end

    // never-loaded entries read as all zeros (disabled)
    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

// ===== sv/dtgm_match.sv =====
// Condition compare for one group entry against the current CPU event.
module dtgm_match (
    input  dtgm_pkg::t_entry   i_entry,
    input  dtgm_pkg::t_in_word i_event,
    output logic               o_fire
);
    import dtgm_pkg::*;

    logic [CONDS-1:0] eq;
    logic [CONDS-1:0] ok;

    always_comb begin
        eq[0] = (i_entry.pc          == i_event.pc);
        eq[1] = (i_entry.acc         == i_event.acc);
        eq[2] = (i_entry.xreg        == i_event.xreg);
        eq[3] = (i_entry.yreg        == i_event.yreg);
        eq[4] = (i_entry.read_addr   == i_event.read_addr);
        eq[5] = (i_entry.write_addr  == i_event.write_addr);
        eq[6] = (i_entry.read_value  == i_event.read_value);
        eq[7] = (i_entry.write_value == i_event.write_value);
        ok    = ~i_entry.conds | (i_event.flags & eq);
        o_fire = i_entry.group_en && (i_entry.conds != '0) && (&ok);
    end

endmodule
